/* hdl/ncas_pkg.sv */
`default_nettype none
package ncas_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DIMS   = 8;
  localparam int COORD_BITS = 16;

  // Fixed field widths at the ports
  localparam int COORD_W   = 16;
  localparam int CLUSTER_W = 6;
  localparam int CFG_W     = 4;
  localparam int DIMS_RESET = 2;

  localparam int PT_IW  = $clog2(MAX_POINTS);
  localparam int PT_CW  = $clog2(MAX_POINTS + 1);
  localparam int DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DIM_CW = $clog2(MAX_DIMS + 1);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ACC_W  = SQ_W + DIM_IW;

  localparam int PSTORE_DEPTH = MAX_POINTS << DIM_IW;
  localparam int PADDR_W      = PT_IW + DIM_IW;

  typedef struct packed {
    logic clr;
    logic sub;
    logic mul;
    logic acc;
    logic cmp;
    logic first;
  } dist_ctl_t;

  typedef struct packed {
    logic take;
  } dist_sts_t;

endpackage
`default_nettype wire

/* hdl/ncas_ram.sv */
`default_nettype none
module ncas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/ncas_dist_unit.sv */
`default_nettype none
module ncas_dist_unit (
  input  logic                                clk_i,
  input  ncas_pkg::dist_ctl_t                 ctl_i,
  input  logic [ncas_pkg::COORD_BITS-1:0]     a_i,
  input  logic [ncas_pkg::COORD_BITS-1:0]     b_i,
  output ncas_pkg::dist_sts_t                 sts_o
);
  import ncas_pkg::*;

  logic signed [DIFF_W-1:0] diff_q;
  logic        [DIFF_W-1:0] mag;
  logic        [SQ_W-1:0]   prod_q;
  logic        [ACC_W-1:0]  acc_q;
  logic        [ACC_W-1:0]  best_q;

  // Magnitude of the difference fits DIFF_W bits even for the most negative value
  assign mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

  assign sts_o.take = ctl_i.first || (acc_q < best_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.sub) begin
      diff_q <= DIFF_W'($signed(a_i)) - DIFF_W'($signed(b_i));
    end
    if (ctl_i.mul) begin
      prod_q <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctl_i.cmp && sts_o.take) begin
      best_q <= acc_q;
    end
  end

endmodule
`default_nettype wire

/* hdl/nearest_center_assignment.sv */
`default_nettype none
// Loading: one coordinate transaction per cycle, busy_o stays low until the end-of-set item.
// Assignment: each point passes the mark, check and emit states; a center point or a set with
// no centers goes straight from check to emit, while any other point first visits every center
// in turn on the shared subtract / square / accumulate unit, one coordinate at a time.
// Results are strobed one cycle each and cannot be stalled; busy_o drops after the last one.
// Reset: idle, set counters cleared, dims_in_use = 2; stores are not cleared.
module nearest_center_assignment (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [ncas_pkg::COORD_W-1:0]  coordinate_i,
  input  logic                                 is_center_i,
  input  logic                                 end_of_set_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ncas_pkg::CFG_W-1:0]           cfg_dims_in_use_i,
  output logic                                 result_valid_o,
  output logic [ncas_pkg::CLUSTER_W-1:0]       cluster_o,
  output logic                                 last_result_o,
  output logic                                 overflowed_o
);
  import ncas_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MARK  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_LIST  = 4'd3;
  localparam logic [3:0] S_LOADC = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_SUB   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [CFG_W-1:0]  dims_q, dims_d;
  logic [PT_CW-1:0]  pc_q, pc_d;
  logic [PT_CW-1:0]  cc_q, cc_d;
  logic [DIM_IW-1:0] coord_cnt_q, coord_cnt_d;
  logic              ovf_q, ovf_d;
  logic              cur_center_q, cur_center_d;
  logic [PT_IW-1:0]  p_q, p_d;
  logic [PT_IW-1:0]  c_q, c_d;
  logic [DIM_IW-1:0] d_q, d_d;
  logic [PT_IW-1:0]  cen_seen_q, cen_seen_d;
  logic [PT_IW-1:0]  clu_q, clu_d;
  logic [PT_IW-1:0]  cpt_q, cpt_d;

  logic [DIM_CW-1:0]     act_dims;
  logic [DIM_IW-1:0]     ccnt_eff;
  logic                  stored;
  logic                  complete;
  logic                  cur_mark;
  logic                  last_pt;
  logic [COORD_BITS-1:0] coord;

  logic                  pt_we;
  logic                  mark_we;
  logic                  list_we;
  logic [PADDR_W-1:0]    pt_waddr;
  logic [PT_IW-1:0]      list_waddr;
  logic [COORD_BITS-1:0] pa_rdata, pb_rdata;
  logic                  mark_rdata;
  logic [PT_IW-1:0]      list_rdata;

  dist_ctl_t dist_ctl;
  dist_sts_t dist_sts;

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = !busy_o;
  assign result_valid_o = (state_q == S_EMIT);
  assign cluster_o      = CLUSTER_W'(clu_q);
  assign last_pt        = ((PT_CW'(p_q) + PT_CW'(1)) == pc_q);
  assign last_result_o  = last_pt;
  assign overflowed_o   = ovf_q;

  assign coord = COORD_BITS'($unsigned(coordinate_i));

  always_comb begin
    if (dims_q == '0) begin
      act_dims = DIM_CW'(1);
    end else if (int'(dims_q) > MAX_DIMS) begin
      act_dims = DIM_CW'(MAX_DIMS);
    end else begin
      act_dims = DIM_CW'(dims_q);
    end
  end

  // Clamp the coordinate slot when dims shrank mid-point
  assign ccnt_eff = (DIM_CW'(coord_cnt_q) >= act_dims) ? DIM_IW'(act_dims - DIM_CW'(1))
                                                        : coord_cnt_q;
  assign stored   = (pc_q < PT_CW'(MAX_POINTS));
  assign complete = ((DIM_CW'(ccnt_eff) + DIM_CW'(1)) >= act_dims);
  assign cur_mark = (ccnt_eff == '0) ? is_center_i : cur_center_q;

  assign pt_waddr   = {pc_q[PT_IW-1:0], ccnt_eff};
  assign list_waddr = cc_q[PT_IW-1:0] & PT_IW'(MAX_POINTS - 1);

  assign dist_ctl.clr   = (state_q == S_LOADC);
  assign dist_ctl.sub   = (state_q == S_SUB);
  assign dist_ctl.mul   = (state_q == S_MUL);
  assign dist_ctl.acc   = (state_q == S_ACC);
  assign dist_ctl.cmp   = (state_q == S_CMP);
  assign dist_ctl.first = (c_q == '0);

  always_comb begin
    state_d      = state_q;
    dims_d       = dims_q;
    pc_d         = pc_q;
    cc_d         = cc_q;
    coord_cnt_d  = coord_cnt_q;
    ovf_d        = ovf_q;
    cur_center_d = cur_center_q;
    p_d          = p_q;
    c_d          = c_q;
    d_d          = d_q;
    cen_seen_d   = cen_seen_q;
    clu_d        = clu_q;
    cpt_d        = cpt_q;
    pt_we        = 1'b0;
    mark_we      = 1'b0;
    list_we      = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      dims_d = cfg_dims_in_use_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pt_we   = stored;
          mark_we = stored && (ccnt_eff == '0);
          if (!stored) begin
            ovf_d = 1'b1;
          end
          if (stored && (ccnt_eff == '0)) begin
            cur_center_d = is_center_i;
          end
          if (complete) begin
            coord_cnt_d = '0;
            if (stored) begin
              if (cur_mark) begin
                list_we = 1'b1;
                cc_d    = cc_q + PT_CW'(1);
              end
              pc_d = pc_q + PT_CW'(1);
            end
          end else begin
            coord_cnt_d = end_of_set_i ? '0 : ccnt_eff + DIM_IW'(1);
          end
          if (end_of_set_i) begin
            p_d        = '0;
            cen_seen_d = '0;
            if (pc_d == '0) begin
              // empty set: nothing to report, just clear
              cc_d        = '0;
              ovf_d       = 1'b0;
              coord_cnt_d = '0;
            end else begin
              state_d = S_MARK;
            end
          end
        end
      end
      S_MARK: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (mark_rdata) begin
          clu_d      = cen_seen_q;
          cen_seen_d = cen_seen_q + PT_IW'(1);
          state_d    = S_EMIT;
        end else if (cc_q == '0) begin
          clu_d   = '0;
          state_d = S_EMIT;
        end else begin
          c_d     = '0;
          state_d = S_LIST;
        end
      end
      S_LIST: begin
        state_d = S_LOADC;
      end
      S_LOADC: begin
        cpt_d   = list_rdata;
        d_d     = '0;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_SUB;
      end
      S_SUB: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if ((DIM_CW'(d_q) + DIM_CW'(1)) < act_dims) begin
          d_d     = d_q + DIM_IW'(1);
          state_d = S_RD;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (dist_sts.take) begin
          clu_d = c_q;
        end
        if ((PT_CW'(c_q) + PT_CW'(1)) < cc_q) begin
          c_d     = c_q + PT_IW'(1);
          state_d = S_LIST;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        p_d = p_q + PT_IW'(1);
        if (last_pt) begin
          pc_d        = '0;
          cc_d        = '0;
          coord_cnt_d = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end else begin
          state_d = S_MARK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dims_q       <= CFG_W'(DIMS_RESET);
      pc_q         <= '0;
      cc_q         <= '0;
      coord_cnt_q  <= '0;
      ovf_q        <= 1'b0;
      cur_center_q <= 1'b0;
      p_q          <= '0;
      c_q          <= '0;
      d_q          <= '0;
      cen_seen_q   <= '0;
    end else begin
      state_q      <= state_d;
      dims_q       <= dims_d;
      pc_q         <= pc_d;
      cc_q         <= cc_d;
      coord_cnt_q  <= coord_cnt_d;
      ovf_q        <= ovf_d;
      cur_center_q <= cur_center_d;
      p_q          <= p_d;
      c_q          <= c_d;
      d_q          <= d_d;
      cen_seen_q   <= cen_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clu_q <= clu_d;
    cpt_q <= cpt_d;
  end

  // Two copies of the point store: one read port for the point, one for the center
  ncas_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (PSTORE_DEPTH)
  ) u_pstore_a (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (coord),
    .raddr_i ({p_q, d_q}),
    .rdata_o (pa_rdata)
  );

  ncas_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (PSTORE_DEPTH)
  ) u_pstore_b (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (coord),
    .raddr_i ({cpt_q, d_q}),
    .rdata_o (pb_rdata)
  );

  ncas_ram #(
    .WIDTH (1),
    .DEPTH (MAX_POINTS)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (pc_q[PT_IW-1:0]),
    .wdata_i (is_center_i),
    .raddr_i (p_q),
    .rdata_o (mark_rdata)
  );

  ncas_ram #(
    .WIDTH (PT_IW),
    .DEPTH (MAX_POINTS)
  ) u_clist (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (pc_q[PT_IW-1:0]),
    .raddr_i (c_q),
    .rdata_o (list_rdata)
  );

  ncas_dist_unit u_dist (
    .clk_i (clk_i),
    .ctl_i (dist_ctl),
    .a_i   (pa_rdata),
    .b_i   (pb_rdata),
    .sts_o (dist_sts)
  );

`ifndef NO_ASSERTIONS
  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |=> !busy_o && (pc_q == '0))
    else $error("block still busy after the last result");

  a_more_stays_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> busy_o && !result_valid_o)
    else $error("result sequence broken before the last result");

  a_centers_le_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cc_q <= pc_q) && (pc_q <= PT_CW'(MAX_POINTS)))
    else $error("center or point count out of range");

  a_busy_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (pc_q != '0))
    else $error("assignment running on an empty set");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS  = ncas_pkg::MAX_POINTS;
  localparam int NDIMS = ncas_pkg::MAX_DIMS;
  localparam logic [ncas_pkg::CFG_W-1:0] DIMS_AT_RESET = 4'(ncas_pkg::DIMS_RESET);

  typedef logic signed [ncas_pkg::COORD_W-1:0] coord_t;
  typedef logic [36:0] dist_t;

  typedef struct packed {
    logic [ncas_pkg::CLUSTER_W-1:0] cluster;
    logic                           last;
    logic                           overflowed;
  } assignment_t;

  typedef enum int {SPREAD_TIGHT, SPREAD_WIDE, SPREAD_EDGES} spread_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  coord_t                        coordinate_i;
  logic                          is_center_i;
  logic                          end_of_set_i;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ncas_pkg::CFG_W-1:0]    cfg_dims_in_use_i;
  logic                          result_valid_o;
  logic [ncas_pkg::CLUSTER_W-1:0] cluster_o;
  logic                          last_result_o;
  logic                          overflowed_o;

  nearest_center_assignment dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .coordinate_i      (coordinate_i),
    .is_center_i       (is_center_i),
    .end_of_set_i      (end_of_set_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_dims_in_use_i (cfg_dims_in_use_i),
    .result_valid_o    (result_valid_o),
    .cluster_o         (cluster_o),
    .last_result_o     (last_result_o),
    .overflowed_o      (overflowed_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the set being loaded
  coord_t                 point_mem [NPTS][NDIMS];
  logic                   center_mark [NPTS];
  logic [5:0]             center_idx [NPTS];
  logic [6:0]             centers_held;
  logic [6:0]             points_held;
  logic [2:0]             coord_pos;
  logic                   overflow_hit;
  logic [ncas_pkg::CFG_W-1:0] dims_reg;
  assignment_t            expected_assignments [$];
  assignment_t            head;

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  sets_closed   = 0;
  int  overflow_sets = 0;
  int  dims_writes   = 0;
  bit  gaps_on       = 1'b1;

  function automatic int dims_active();
    if (dims_reg == 0) return 1;
    if (dims_reg > NDIMS) return NDIMS;
    return int'(dims_reg);
  endfunction

  function automatic dist_t squared_gap(int a, int b, int dims);
    dist_t              acc;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [33:0]        sq;
    acc = '0;
    for (int d = 0; d < dims; d++) begin
      diff = {point_mem[a][d][15], point_mem[a][d]} - {point_mem[b][d][15], point_mem[b][d]};
      mag  = (diff < 0) ? -diff : diff;
      sq   = mag * mag;
      acc  = acc + sq;
    end
    return acc;
  endfunction

  // Advance the shadow set by one coordinate; on end of set queue one assignment per point.
  task automatic predict_assignment(coord_t value, logic centre, logic last_item);
    int          dims;
    bit          stored;
    int          clu;
    dist_t       best;
    dist_t       gap;
    assignment_t item;
    dims   = dims_active();
    stored = points_held < NPTS;
    if (coord_pos >= dims) coord_pos = 3'(dims - 1);
    if (stored) begin
      point_mem[points_held[5:0]][coord_pos] = value;
      if (coord_pos == 0) center_mark[points_held[5:0]] = centre;
    end else begin
      overflow_hit = 1'b1;
    end
    if (coord_pos + 1 >= dims) begin
      coord_pos = '0;
      if (stored) begin
        if (center_mark[points_held[5:0]]) begin
          center_idx[centers_held[5:0]] = points_held[5:0];
          centers_held++;
        end
        points_held++;
      end
    end else begin
      coord_pos++;
      // drop a partial point
      if (last_item) coord_pos = '0;
    end
    if (!last_item) return;

    for (int p = 0; p < points_held; p++) begin
      clu = 0;
      if (center_mark[p]) begin
        for (int c = centers_held - 1; c >= 0; c--)
          if (center_idx[c] == p) clu = c;
      end else if (centers_held > 0) begin
        best = squared_gap(p, int'(center_idx[0]), dims);
        for (int c = 1; c < centers_held; c++) begin
          gap = squared_gap(p, int'(center_idx[c]), dims);
          if (gap < best) begin
            best = gap;
            clu  = c;
          end
        end
      end
      item = '{cluster: clu[5:0], last: (p + 1 == points_held), overflowed: overflow_hit};
      expected_assignments.insert(expected_assignments.size(), item);
    end
    sets_closed++;
    if (overflow_hit) overflow_sets++;
    centers_held = '0;
    points_held  = '0;
    coord_pos    = '0;
    overflow_hit = 1'b0;
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (expected_assignments.size() == 0) begin
        report_mismatch($sformatf("cluster %0d arrived with nothing expected", cluster_o));
      end else begin
        head = expected_assignments.pop_front();
        if (cluster_o !== head.cluster || last_result_o !== head.last ||
            overflowed_o !== head.overflowed)
          report_mismatch($sformatf("cluster %0d/%0d last %0b/%0b overflowed %0b/%0b (got/want)",
                                    cluster_o, head.cluster, last_result_o, head.last,
                                    overflowed_o, head.overflowed));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction with start held.
  task automatic send_coordinate(coord_t value, logic centre, logic last_item);
    if (gaps_on)
      while ($urandom_range(99) < 20) begin
        start_i = 1'b0;
        @(negedge clk_i);
      end
    start_i      = 1'b1;
    coordinate_i = value;
    is_center_i  = centre;
    end_of_set_i = last_item;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    predict_assignment(value, centre, last_item);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start_i = 1'b0;
    do @(posedge clk_i); while (busy_o || expected_assignments.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_dims(logic [ncas_pkg::CFG_W-1:0] value);
    start_i           = 1'b0;
    cfg_valid_i       = 1'b1;
    cfg_dims_in_use_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    dims_reg = value;
    dims_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic coord_t pick_coord(spread_e spread);
    int v;
    case (spread)
      SPREAD_TIGHT: begin
        v = $urandom_range(16);
        return coord_t'(v - 8);
      end
      SPREAD_WIDE: return coord_t'($urandom());
      default: begin
        v = $urandom_range(3);
        if (v == 0) return coord_t'(-32768);
        if (v == 1) return coord_t'(32767);
        if (v == 2) return coord_t'(0);
        return coord_t'($urandom());
      end
    endcase
  endfunction

  function automatic logic [ncas_pkg::CFG_W-1:0] pick_dims();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 4'($urandom_range(3, 1));
    if (r < 8) return 4'($urandom_range(8, 4));
    return 4'($urandom_range(15));
  endfunction

  // Reset dims, extreme coordinates, ties, no centers, partial and empty sets.
  task automatic test_directed();
    send_coordinate(-32768, 1'b1, 1'b0);
    send_coordinate(-32768, 1'b0, 1'b0);
    send_coordinate(32767, 1'b0, 1'b0);
    send_coordinate(32767, 1'b0, 1'b0);
    // center flag on a later coordinate is ignored
    send_coordinate(32767, 1'b1, 1'b0);
    send_coordinate(32767, 1'b1, 1'b0);
    send_coordinate(0, 1'b0, 1'b0);
    send_coordinate(0, 1'b0, 1'b0);
    send_coordinate(-1, 1'b0, 1'b0);
    send_coordinate(-1, 1'b0, 1'b1);
    wait_idle();
    write_dims(4'd0);
    send_coordinate(5, 1'b0, 1'b0);
    send_coordinate(-7, 1'b0, 1'b1);
    wait_idle();
    write_dims(4'd1);
    send_coordinate(100, 1'b1, 1'b0);
    send_coordinate(300, 1'b1, 1'b0);
    send_coordinate(200, 1'b0, 1'b0);
    send_coordinate(-5, 1'b0, 1'b0);
    send_coordinate(400, 1'b0, 1'b1);
    wait_idle();
    write_dims(4'd2);
    send_coordinate(1, 1'b1, 1'b0);
    send_coordinate(2, 1'b0, 1'b0);
    send_coordinate(3, 1'b0, 1'b1);
    send_coordinate(9, 1'b1, 1'b1);
    wait_idle();
  endtask

  // Shrink dims in the middle of a point, then run a set at the top clamp.
  task automatic test_dims_change_mid_set();
    write_dims(4'd4);
    send_coordinate(1, 1'b1, 1'b0);
    send_coordinate(2, 1'b0, 1'b0);
    send_coordinate(3, 1'b0, 1'b0);
    send_coordinate(4, 1'b0, 1'b0);
    send_coordinate(10, 1'b0, 1'b0);
    send_coordinate(20, 1'b0, 1'b0);
    send_coordinate(30, 1'b0, 1'b0);
    wait_idle();
    write_dims(4'd2);
    send_coordinate(40, 1'b0, 1'b0);
    send_coordinate(50, 1'b1, 1'b0);
    send_coordinate(60, 1'b0, 1'b0);
    send_coordinate(30, 1'b0, 1'b0);
    send_coordinate(50, 1'b0, 1'b1);
    wait_idle();
    write_dims(4'd15);
    for (int i = 0; i < 3 * NDIMS; i++)
      send_coordinate(pick_coord(SPREAD_WIDE), i < 2 * NDIMS, i == 3 * NDIMS - 1);
    wait_idle();
  endtask

  // Fill the store past capacity; nearly every point is a center so high cluster numbers show.
  task automatic test_overflow();
    write_dims(4'd1);
    for (int p = 0; p < NPTS + 2; p++)
      send_coordinate(pick_coord(SPREAD_WIDE), (p % 16) != 5, p == NPTS + 1);
    wait_idle();
  endtask

  task automatic send_random_set();
    int      dims;
    int      npts;
    int      extra;
    int      total;
    spread_e spread;
    dims  = dims_active();
    npts  = ($urandom_range(19) < 17) ? $urandom_range(8, 1) : $urandom_range(24, 9);
    if (npts * dims > 48) npts = 48 / dims;
    extra = 0;
    if (dims > 1 && $urandom_range(9) == 0) begin
      extra = $urandom_range(dims - 1, 1);
      // nothing complete: the set yields no results
      if ($urandom_range(3) == 0) npts = 0;
    end
    spread = spread_e'($urandom_range(2));
    total  = npts * dims + extra;
    for (int i = 0; i < total; i++)
      send_coordinate(pick_coord(spread), $urandom_range(99) < 30, i == total - 1);
  endtask

  task automatic test_random_sets(int item_target);
    int r;
    while (items_sent < item_target) begin
      gaps_on = (items_sent < 180 || items_sent >= 250);
      r = $urandom_range(11);
      if (r < 3) begin
        wait_idle();
        write_dims(pick_dims());
      end else if (r == 3) begin
        wait_idle();
      end
      send_random_set();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    coordinate_i      = '0;
    is_center_i       = 1'b0;
    end_of_set_i      = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_dims_in_use_i = DIMS_AT_RESET;
    for (int p = 0; p < NPTS; p++) begin
      center_mark[p] = 1'b0;
      center_idx[p]  = '0;
      for (int d = 0; d < NDIMS; d++) point_mem[p][d] = '0;
    end
    centers_held = '0;
    points_held  = '0;
    coord_pos    = '0;
    overflow_hit = 1'b0;
    dims_reg     = DIMS_AT_RESET;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_dims_change_mid_set();
    test_overflow();
    test_random_sets(280);
    wait_idle();

    $display("run covered %0d closed sets, %0d coordinate transactions, %0d cluster results",
             sets_closed, items_sent, results_seen);
    $display("dims written %0d times (clamps at 0 and 15, one mid-point), %0d overflowed sets",
             dims_writes, overflow_sets);
    if (mismatches == 0 && expected_assignments.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_assignments.size());
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
